FILE: design/spta_pkg.sv
// Package for the sparse polynomial term accumulator: item structs, status codes,
// the microcode control word and the read-only microprogram. No dependencies.
package spta_pkg;

   localparam int MAX_TERMS = 16;
   localparam int IDX_W     = $clog2(MAX_TERMS);
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int EXP_W     = 16;
   localparam int COEF_W    = 32;
   localparam int PC_W      = 5;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_MERGED   = 3'd1;
   localparam logic [2:0] ST_REMOVED  = 3'd2;
   localparam logic [2:0] ST_IGNORED  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_TERM     = 3'd5;
   localparam logic [2:0] ST_EMPTY    = 3'd6;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [EXP_W-1:0]         term_exponent;
      logic signed [COEF_W-1:0] term_coefficient;
   } req_item_type;

   typedef struct packed {
      logic [2:0]               status;
      logic [EXP_W-1:0]         out_exponent;
      logic signed [COEF_W-1:0] out_coefficient;
      logic                     last;
   } rsp_item_type;

   // Datapath operations carried by one control word.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LATCH,
      OP_SCAN,
      OP_SUM,
      OP_MERGE,
      OP_REMOVE,
      OP_INSERT,
      OP_READ
   } op_type;

   // Jump conditions; when the condition holds the step counter loads the target.
   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NOT_START,
      CND_IS_READ,
      CND_COEF_ZERO,
      CND_SCAN_MORE,
      CND_NO_MATCH,
      CND_SUM_ZERO,
      CND_FULL,
      CND_EMPTY,
      CND_READ_MORE
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            emit;
      logic [2:0]      status;
   } ctrl_word_type;

   // Microprogram step addresses.
   localparam logic [PC_W-1:0] PC_WAIT     = 5'd0;
   localparam logic [PC_W-1:0] PC_DISPATCH = 5'd1;
   localparam logic [PC_W-1:0] PC_ZCHECK   = 5'd2;
   localparam logic [PC_W-1:0] PC_SCAN     = 5'd3;
   localparam logic [PC_W-1:0] PC_MATCH    = 5'd4;
   localparam logic [PC_W-1:0] PC_SUM      = 5'd5;
   localparam logic [PC_W-1:0] PC_SZCHECK  = 5'd6;
   localparam logic [PC_W-1:0] PC_MERGE    = 5'd7;
   localparam logic [PC_W-1:0] PC_REMOVE   = 5'd8;
   localparam logic [PC_W-1:0] PC_FCHECK   = 5'd9;
   localparam logic [PC_W-1:0] PC_INSERT   = 5'd10;
   localparam logic [PC_W-1:0] PC_DROP     = 5'd11;
   localparam logic [PC_W-1:0] PC_IGNORE   = 5'd12;
   localparam logic [PC_W-1:0] PC_RCHECK   = 5'd13;
   localparam logic [PC_W-1:0] PC_READ     = 5'd14;
   localparam logic [PC_W-1:0] PC_RDONE    = 5'd15;
   localparam logic [PC_W-1:0] PC_REMPTY   = 5'd16;

   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NONE, cond: CND_ALWAYS, target: PC_WAIT, emit: 1'b0, status: ST_INSERTED};
      unique case (pc)
         PC_WAIT:     begin w.op = OP_LATCH; w.cond = CND_NOT_START; w.target = PC_WAIT; end
         PC_DISPATCH: begin w.cond = CND_IS_READ;   w.target = PC_RCHECK; end
         PC_ZCHECK:   begin w.cond = CND_COEF_ZERO; w.target = PC_IGNORE; end
         PC_SCAN:     begin w.op = OP_SCAN; w.cond = CND_SCAN_MORE; w.target = PC_SCAN; end
         PC_MATCH:    begin w.cond = CND_NO_MATCH;  w.target = PC_FCHECK; end
         PC_SUM:      begin w.op = OP_SUM; w.cond = CND_NEVER; end
         PC_SZCHECK:  begin w.cond = CND_SUM_ZERO;  w.target = PC_REMOVE; end
         PC_MERGE:    begin w.op = OP_MERGE; w.emit = 1'b1; w.status = ST_MERGED; end
         PC_REMOVE:   begin w.op = OP_REMOVE; w.emit = 1'b1; w.status = ST_REMOVED; end
         PC_FCHECK:   begin w.cond = CND_FULL; w.target = PC_DROP; end
         PC_INSERT:   begin w.op = OP_INSERT; w.emit = 1'b1; w.status = ST_INSERTED; end
         PC_DROP:     begin w.emit = 1'b1; w.status = ST_FULL; end
         PC_IGNORE:   begin w.emit = 1'b1; w.status = ST_IGNORED; end
         PC_RCHECK:   begin w.cond = CND_EMPTY; w.target = PC_REMPTY; end
         PC_READ:     begin
            w.op = OP_READ; w.cond = CND_READ_MORE; w.target = PC_READ;
            w.emit = 1'b1; w.status = ST_TERM;
         end
         PC_RDONE:    begin w.cond = CND_ALWAYS; w.target = PC_WAIT; end
         PC_REMPTY:   begin w.emit = 1'b1; w.status = ST_EMPTY; end
         default:     begin w.cond = CND_ALWAYS; w.target = PC_WAIT; end
      endcase
      return w;
   endfunction

endpackage

FILE: design/sparse_polynomial_term_accumulator_unit.sv
// Top level of the sparse polynomial term accumulator: microcoded sequencer and
// term table datapath. Depends on spta_pkg.
//
// Usage. An item is offered on req_data with start; it is taken at a rising edge
// where start is high and busy is low. An add item (req_type 0) yields exactly one
// result item with the outcome in status. A readout item (req_type 1) yields one
// result item per stored term, highest exponent first, with last set on the final
// one, or a single empty result when the table holds no terms.
// Results appear on rsp_data for exactly one cycle, marked by rsp_valid, and the
// receiver cannot hold them off; the block never stalls on the result side.
// Timing. Control runs from a read-only microprogram, one control word per cycle.
// While an add item keeps busy high, the scan loop walks the table one entry a
// cycle until it finds the first exponent not above the new one or the end of the
// valid entries. A readout keeps busy high while it emits one term a cycle from
// the single table read port.
// The result strobe is registered from its step, so after an add item or an empty
// readout a new item may be accepted in the same cycle as that result is shown.
// Reset clears the step counter, walking index, term count and result strobe; the
// table contents are left as they are, as entries beyond the count are never read.

module sparse_polynomial_term_accumulator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  spta_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   output spta_pkg::rsp_item_type rsp_data
);

   // Step counter and current control word.
   logic [spta_pkg::PC_W-1:0] pc_ff, pc_in;
   spta_pkg::ctrl_word_type   cw;

   // Working registers.
   logic [spta_pkg::CNT_W-1:0]         idx_ff, idx_in;
   logic [spta_pkg::CNT_W-1:0]         count_ff, count_in;
   spta_pkg::req_item_type             req_ff;
   logic signed [spta_pkg::COEF_W-1:0] sum_ff;
   logic                               rsp_valid_ff;
   spta_pkg::rsp_item_type             rsp_ff;

   // Term table, kept sorted by descending exponent in entries below the count.
   logic [spta_pkg::EXP_W-1:0]         exp_ff  [spta_pkg::MAX_TERMS];
   logic signed [spta_pkg::COEF_W-1:0] coef_ff [spta_pkg::MAX_TERMS];

   // Single read port into the table, addressed by the walking index.
   logic [spta_pkg::IDX_W-1:0]         rd_addr;
   logic [spta_pkg::EXP_W-1:0]         rd_exp;
   logic signed [spta_pkg::COEF_W-1:0] rd_coef;

   logic                               at_end;
   logic                               scan_stop;
   logic                               match;
   logic                               read_more;
   logic [spta_pkg::CNT_W-1:0]         idx_next;
   logic signed [spta_pkg::COEF_W:0]   wide_sum;
   logic signed [spta_pkg::COEF_W-1:0] sat_sum;
   logic                               cond_hit;

   assign cw      = spta_pkg::ucode_rom(pc_ff);
   assign rd_addr = idx_ff[spta_pkg::IDX_W-1:0];
   assign rd_exp  = exp_ff[rd_addr];
   assign rd_coef = coef_ff[rd_addr];

   assign idx_next  = idx_ff + spta_pkg::CNT_W'(1);
   assign at_end    = (idx_ff == count_ff);
   // The scan stops at the end of the valid entries or at the first exponent
   // that is not above the new one: that entry is either the match or the slot.
   assign scan_stop = at_end || (rd_exp <= req_ff.term_exponent);
   assign match     = !at_end && (rd_exp == req_ff.term_exponent);
   assign read_more = (idx_next < count_ff);

   // Signed add with one guard bit; a disagreement of the two top bits is overflow.
   assign wide_sum = {rd_coef[spta_pkg::COEF_W-1], rd_coef}
                   + {req_ff.term_coefficient[spta_pkg::COEF_W-1], req_ff.term_coefficient};
   always_comb begin
      if (wide_sum[spta_pkg::COEF_W] != wide_sum[spta_pkg::COEF_W-1]) begin
         if (wide_sum[spta_pkg::COEF_W]) begin
            sat_sum = {1'b1, {(spta_pkg::COEF_W-1){1'b0}}};
         end else begin
            sat_sum = {1'b0, {(spta_pkg::COEF_W-1){1'b1}}};
         end
      end else begin
         sat_sum = wide_sum[spta_pkg::COEF_W-1:0];
      end
   end

   // Jump condition selection.
   always_comb begin
      unique case (cw.cond)
         spta_pkg::CND_NEVER:     cond_hit = 1'b0;
         spta_pkg::CND_ALWAYS:    cond_hit = 1'b1;
         spta_pkg::CND_NOT_START: cond_hit = !start;
         spta_pkg::CND_IS_READ:   cond_hit = (req_ff.req_type == spta_pkg::REQ_READ);
         spta_pkg::CND_COEF_ZERO: cond_hit = (req_ff.term_coefficient == '0);
         spta_pkg::CND_SCAN_MORE: cond_hit = !scan_stop;
         spta_pkg::CND_NO_MATCH:  cond_hit = !match;
         spta_pkg::CND_SUM_ZERO:  cond_hit = (sum_ff == '0);
         spta_pkg::CND_FULL:      cond_hit = (count_ff == spta_pkg::CNT_W'(spta_pkg::MAX_TERMS));
         spta_pkg::CND_EMPTY:     cond_hit = (count_ff == '0);
         spta_pkg::CND_READ_MORE: cond_hit = read_more;
         default:                 cond_hit = 1'b1;
      endcase
   end

   assign pc_in = cond_hit ? cw.target : pc_ff + spta_pkg::PC_W'(1);
   assign busy  = (pc_ff != spta_pkg::PC_WAIT);

   // Index and count updates decoded from the operation field.
   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      case (cw.op)
         spta_pkg::OP_LATCH:  idx_in = '0;
         spta_pkg::OP_SCAN:   if (!scan_stop) idx_in = idx_next;
         spta_pkg::OP_READ:   idx_in = idx_next;
         spta_pkg::OP_INSERT: count_in = count_ff + spta_pkg::CNT_W'(1);
         spta_pkg::OP_REMOVE: count_in = count_ff - spta_pkg::CNT_W'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= spta_pkg::PC_WAIT;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= cw.emit;
      end
   end

   // Request latch, merge sum and result register carry payload only.
   always_ff @(posedge clock) begin
      if (cw.op == spta_pkg::OP_LATCH && start) begin
         req_ff <= req_data;
      end
      if (cw.op == spta_pkg::OP_SUM) begin
         sum_ff <= sat_sum;
      end
      if (cw.emit) begin
         rsp_ff.status <= cw.status;
         if (cw.op == spta_pkg::OP_READ) begin
            rsp_ff.out_exponent    <= rd_exp;
            rsp_ff.out_coefficient <= rd_coef;
            rsp_ff.last            <= !read_more;
         end else begin
            rsp_ff.out_exponent    <= '0;
            rsp_ff.out_coefficient <= '0;
            rsp_ff.last            <= 1'b1;
         end
      end
   end

   // Table updates. Every entry moves from a fixed neighbour, so insert and
   // remove shift the whole tail at once.
   always_ff @(posedge clock) begin
      for (int j = 0; j < spta_pkg::MAX_TERMS; j++) begin
         unique case (cw.op)
            spta_pkg::OP_MERGE: begin
               if (spta_pkg::CNT_W'(j) == idx_ff) coef_ff[j] <= sum_ff;
            end
            spta_pkg::OP_INSERT: begin
               if (spta_pkg::CNT_W'(j) == idx_ff) begin
                  exp_ff[j]  <= req_ff.term_exponent;
                  coef_ff[j] <= req_ff.term_coefficient;
               end else if (j > 0 && spta_pkg::CNT_W'(j) > idx_ff) begin
                  exp_ff[j]  <= exp_ff[(j > 0) ? j - 1 : 0];
                  coef_ff[j] <= coef_ff[(j > 0) ? j - 1 : 0];
               end
            end
            spta_pkg::OP_REMOVE: begin
               if (j < spta_pkg::MAX_TERMS - 1 && spta_pkg::CNT_W'(j) >= idx_ff) begin
                  exp_ff[j]  <= exp_ff[(j < spta_pkg::MAX_TERMS - 1) ? j + 1 : j];
                  coef_ff[j] <= coef_ff[(j < spta_pkg::MAX_TERMS - 1) ? j + 1 : j];
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/spta_checker.sv
// Port-level checker for the sparse polynomial term accumulator, bound to the top
// level. Depends on spta_pkg and sparse_polynomial_term_accumulator_unit.
module spta_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input spta_pkg::rsp_item_type rsp_data
);

   // An accepted item always raises busy in the cycle after it is taken.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted item");

   // Read-out terms stream on consecutive cycles until the last one.
   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("read-out stream broke before the last item");

   // Only read-out terms can be followed by more results of the same item.
   a_notlast_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.status == spta_pkg::ST_TERM && busy)
      else $error("non-final result that is not a read-out term");

   // Results other than read-out terms carry zero fields and have last set.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != spta_pkg::ST_TERM
         |-> rsp_data.out_exponent == '0 && rsp_data.out_coefficient == '0 && rsp_data.last)
      else $error("status result with non-zero fields");

endmodule

bind sparse_polynomial_term_accumulator_unit spta_checker u_spta_checker (.*);
